FILE: rtl/box_table_overlap_query_defines.svh
// Assertion macros for the box table overlap query block.
// Used by the top level; needs nothing else.
`ifndef BOX_TABLE_OVERLAP_QUERY_DEFINES_SVH
`define BOX_TABLE_OVERLAP_QUERY_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define BTOQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btoq: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define BTOQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btoq: next-cycle check failed");

`endif

FILE: rtl/btoq_pkg.sv
// Shared types, constants and compare function for the box table overlap query.
// No dependencies.
package btoq_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COORD_BITS  = 16;
    localparam int INDEX_BITS  = 6;
    localparam int COUNT_BITS  = 7;

    // Input tdata layout, lowest field first
    localparam int INDEX_LSB    = 0;
    localparam int LEFT_LSB     = INDEX_LSB + INDEX_BITS;
    localparam int TOP_LSB      = LEFT_LSB + COORD_BITS;
    localparam int RIGHT_LSB    = TOP_LSB + COORD_BITS;
    localparam int BOTTOM_LSB   = RIGHT_LSB + COORD_BITS;
    localparam int S_FIELD_BITS = BOTTOM_LSB + COORD_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 8;

    // Operation codes carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic signed [COORD_BITS-1:0] right;
        logic signed [COORD_BITS-1:0] bottom;
    } box_t;

    // Table write broadcast to every cell
    typedef struct packed {
        logic                  en;
        logic [INDEX_BITS-1:0] index;
        box_t                  box;
    } wr_t;

    // Query item moving down the cell chain
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [COUNT_BITS-1:0] remaining;
        box_t                  box;
    } scan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    // One axis of the overlap test; query ends q0/q1, stored ends s0/s1
    function automatic logic axis_pass(
        input logic signed [COORD_BITS-1:0] q0,
        input logic signed [COORD_BITS-1:0] q1,
        input logic signed [COORD_BITS-1:0] s0,
        input logic signed [COORD_BITS-1:0] s1
    );
        axis_pass = (q0 >= s0 && q0 <= s1) || (s0 >= q0 && s0 <= q1) ||
                    (q1 >= s1 && q1 <= s0) || (s1 >= q1 && s1 <= q0);
    endfunction

endpackage

FILE: rtl/btoq_cell.sv
// One cell of the box chain: holds one table entry and tests a passing query.
// Depends on btoq_pkg.
module btoq_cell
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [btoq_pkg::INDEX_BITS-1:0]  position,
    input  btoq_pkg::wr_t                    wr,
    input  btoq_pkg::scan_t                  scan_in,
    output btoq_pkg::scan_t                  scan_out
);
    import btoq_pkg::*;

    box_t  box_reg;
    scan_t scan_reg;
    scan_t scan_next;
    logic  hit;

    // Store the entry when the write targets this cell
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.index == position)
        begin
            box_reg <= wr.box;
        end
    end

    // Test the incoming query against the stored box, count down entries in use
    always_comb
    begin
        hit = axis_pass(scan_in.box.left, scan_in.box.right, box_reg.left, box_reg.right) &&
              axis_pass(scan_in.box.top, scan_in.box.bottom, box_reg.top, box_reg.bottom);
        scan_next = scan_in;
        if (scan_in.remaining != '0)
        begin
            scan_next.found     = scan_in.found | hit;
            scan_next.remaining = scan_in.remaining - COUNT_BITS'(1);
        end
    end

    // Advance the query to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

FILE: rtl/box_table_overlap_query.sv
// Top level of the box table overlap query: stream ports, control and cell chain.
// Depends on btoq_pkg, btoq_cell and box_table_overlap_query_defines.svh.
//
// The table lives in a chain of TABLE_DEPTH cells, one box per cell. For a
// write item, its corners are put in order and the box is stored in the cell
// whose position matches entry_index (the index field covers every entry of
// the table). A query item enters the first cell and moves one cell per cycle,
// each cell checking it against its box while the count of entries in use
// runs out; its answer passes the register of every cell in the chain and
// then goes to the output register. One query is in the chain at a time and
// the input stays closed while it moves, so the next item is taken only after
// the query's answer leaves the chain. A finished answer may wait on the
// output while the next item is taken; if the output register is still full
// when the next answer leaves the chain, that answer is parked and the input
// stays closed until the output register empties. Entries read by a query
// must have been written since reset.
`include "box_table_overlap_query_defines.svh"

module box_table_overlap_query
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration: boxes_in_use
    input  logic                               cfg_we,
    input  logic [btoq_pkg::COUNT_BITS-1:0]    cfg_wdata,
    // Input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index, left, top, right, bottom, zero fill
    input  logic [btoq_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    // operation
    input  logic [0:0]                         s_axis_tuser,
    // Result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // overlap_found, zero fill
    output logic [btoq_pkg::M_TDATA_BITS-1:0]  m_axis_tdata
);
    import btoq_pkg::*;

    logic [COUNT_BITS-1:0] boxes_in_use_reg;
    state_t                state_reg;
    state_t                state_next;
    logic                  hold_reg;
    logic                  m_valid_reg;
    logic                  m_found_reg;

    scan_t                 scan_bus [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] chain_valid;
    wr_t                   wr;
    box_t                  in_box;
    logic                  in_accept;
    logic                  out_free;
    logic                  out_load;
    logic                  out_value;
    logic                  hold_load;

    // Register the count of entries in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boxes_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            boxes_in_use_reg <= cfg_wdata;
        end
    end

    // Unpack the input item
    always_comb
    begin
        in_box.left   = s_axis_tdata[LEFT_LSB +: COORD_BITS];
        in_box.top    = s_axis_tdata[TOP_LSB +: COORD_BITS];
        in_box.right  = s_axis_tdata[RIGHT_LSB +: COORD_BITS];
        in_box.bottom = s_axis_tdata[BOTTOM_LSB +: COORD_BITS];
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Order the corners of a box being written and broadcast it
    always_comb
    begin
        wr.en         = in_accept && (s_axis_tuser[0] == OP_WRITE);
        wr.index      = s_axis_tdata[INDEX_LSB +: INDEX_BITS];
        wr.box.left   = (in_box.right < in_box.left) ? in_box.right : in_box.left;
        wr.box.right  = (in_box.right < in_box.left) ? in_box.left : in_box.right;
        wr.box.top    = (in_box.bottom < in_box.top) ? in_box.bottom : in_box.top;
        wr.box.bottom = (in_box.bottom < in_box.top) ? in_box.top : in_box.bottom;
    end

    // Feed a query into the head of the chain
    always_comb
    begin
        scan_bus[0].valid     = in_accept && (s_axis_tuser[0] == OP_QUERY);
        scan_bus[0].found     = 1'b0;
        scan_bus[0].remaining = boxes_in_use_reg;
        scan_bus[0].box       = in_box;
    end

    // Chain of table cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        btoq_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .position (INDEX_BITS'(i)),
            .wr       (wr),
            .scan_in  (scan_bus[i]),
            .scan_out (scan_bus[i+1])
        );
        assign chain_valid[i] = scan_bus[i+1].valid;
    end

    assign out_free = !m_valid_reg || m_axis_tready;

    // Next state and control
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        out_value     = scan_bus[TABLE_DEPTH].found;
        hold_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tuser[0] == OP_QUERY)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_bus[TABLE_DEPTH].valid)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        hold_load  = 1'b1;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                out_value = hold_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Park an answer while the output register is still full
    always_ff @(posedge clk)
    begin
        if (hold_load)
        begin
            hold_reg <= scan_bus[TABLE_DEPTH].found;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_found_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
            m_found_reg <= out_value;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_BITS-1)'(0), m_found_reg};

    // At most one query in the chain, none while idle, answer only during a scan, output full while parked
    `BTOQ_ASSERT_SAME(a_one_query, clk, rst_n, 1'b1, $countones(chain_valid) <= 1)
    `BTOQ_ASSERT_SAME(a_idle_empty, clk, rst_n, state_reg == ST_IDLE, chain_valid == '0)
    `BTOQ_ASSERT_SAME(a_exit_in_scan, clk, rst_n, scan_bus[TABLE_DEPTH].valid, state_reg == ST_SCAN)
    `BTOQ_ASSERT_SAME(a_hold_full, clk, rst_n, state_reg == ST_HOLD, m_axis_tvalid)

endmodule
